[design/spq_pkg.sv]
// spq_pkg: shared constants and types for the sorted-insert priority queue
// no dependencies; used by the interfaces, the cell and the top level
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         occ_t;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic  push;
    logic  pop;
    data_t value;
  } cell_ctrl_t;

endpackage

[design/spq_if.sv]
// spq_in_if / spq_out_if: valid-ready channels for the priority queue
// depends on spq_pkg
interface spq_in_if;
  logic              valid;
  logic              ready;
  spq_pkg::func_t    func;
  spq_pkg::data_t    value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface spq_out_if;
  logic                         valid;
  logic                         ready;
  spq_pkg::data_t               popped_value;
  spq_pkg::data_t               top_value;
  logic [spq_pkg::COUNT_W-1:0]  entry_count;
  logic                         is_empty;
  spq_pkg::status_t             status;

  modport source (output valid, popped_value, top_value, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, popped_value, top_value, entry_count, is_empty, status,
                  output ready);
endinterface

[design/sorted_insert_priority_queue_core.sv]
// sorted_insert_priority_queue_core: max-priority queue on a row of compare-and-shift cells
// depends on spq_pkg, spq_if (spq_in_if, spq_out_if) and spq_cell
//
//   channel  dir  payload                                                   handshake
//   in_ch    in   func, value                                               valid/ready
//   out_ch   out  popped_value, top_value, entry_count, is_empty, status    valid/ready
//
// all cells compare against the pushed word and shift in parallel, so one push
// or pop is accepted per clock while the result register can take it
// result lands in an output register in the cycle after acceptance
// input stays ready while the result register is empty or being drained
// reset clears the occupancy count and the output valid; cell contents are
// undefined until written and never read beyond the count
module sorted_insert_priority_queue_core (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CAP = spq_pkg::CAPACITY;

  spq_pkg::occ_t       occ_r, occ_nxt;
  logic                out_valid_r;
  spq_pkg::data_t      popped_r, top_r;
  logic [spq_pkg::COUNT_W-1:0] count_r;
  logic                empty_r;
  spq_pkg::status_t    status_r, status_nxt;

  logic                accept, full, empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::data_t      entry   [CAP];
  spq_pkg::data_t      entry_n [CAP];
  logic                below   [CAP];
  spq_pkg::data_t      top_nxt;
  logic [31:0]         occ_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (occ_r == spq_pkg::CNT_W'(CAP));
  assign empty       = (occ_r == '0);

  assign ctrl.push  = accept && (in_ch.func == spq_pkg::FUNC_PUSH) && !full;
  assign ctrl.pop   = accept && (in_ch.func == spq_pkg::FUNC_POP) && !empty;
  assign ctrl.value = in_ch.value;

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      spq_pkg::data_t prev_e, next_e;
      logic           prev_b;
      if (gi == 0) begin : g_first
        assign prev_e = entry[0];
        assign prev_b = 1'b0;
      end else begin : g_mid
        assign prev_e = entry[gi-1];
        assign prev_b = below[gi-1];
      end
      if (gi == CAP - 1) begin : g_last
        assign next_e = entry[gi];
      end else begin : g_inner
        assign next_e = entry[gi+1];
      end
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .slot_valid (spq_pkg::CNT_W'(gi) < occ_r),
        .prev_entry (prev_e),
        .prev_below (prev_b),
        .next_entry (next_e),
        .entry      (entry[gi]),
        .entry_nxt  (entry_n[gi]),
        .below      (below[gi])
      );
    end
  endgenerate

  always_comb begin
    occ_nxt    = occ_r;
    status_nxt = spq_pkg::ST_OK;
    if (ctrl.push) begin
      occ_nxt = occ_r + spq_pkg::CNT_W'(1);
    end else if (ctrl.pop) begin
      occ_nxt = occ_r - spq_pkg::CNT_W'(1);
    end
    if (accept && (in_ch.func == spq_pkg::FUNC_PUSH) && full) begin
      status_nxt = spq_pkg::ST_FULL;
    end else if (accept && (in_ch.func == spq_pkg::FUNC_POP) && empty) begin
      status_nxt = spq_pkg::ST_EMPTY;
    end
  end

  // largest entry always sits in cell 0
  assign top_nxt = (occ_nxt == '0) ? '0 : entry_n[0];
  assign occ_ext = 32'(occ_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= ctrl.pop ? entry[0] : '0;
      top_r    <= top_nxt;
      count_r  <= occ_ext[spq_pkg::COUNT_W-1:0];
      empty_r  <= (occ_nxt == '0);
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.top_value    = top_r;
  assign out_ch.entry_count  = count_r;
  assign out_ch.is_empty     = empty_r;
  assign out_ch.status       = status_r;

endmodule

[design/spq_cell.sv]
// spq_cell: one slot of the descending sorted row, largest entry at cell 0
// depends on spq_pkg; instantiated in a row by sorted_insert_priority_queue_core
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                slot_valid,
  input  spq_pkg::data_t      prev_entry,
  input  logic                prev_below,
  input  spq_pkg::data_t      next_entry,
  output spq_pkg::data_t      entry,
  output spq_pkg::data_t      entry_nxt,
  output logic                below
);

  spq_pkg::data_t entry_r;

  // entry is absent or strictly smaller than the pushed word
  assign below = !(slot_valid && (entry_r >= ctrl.value));

  always_comb begin
    priority if (ctrl.push) begin
      if (prev_below) begin
        entry_nxt = prev_entry;
      end else if (below) begin
        entry_nxt = ctrl.value;
      end else begin
        entry_nxt = entry_r;
      end
    end else if (ctrl.pop) begin
      entry_nxt = next_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[tb/sorted_insert_priority_queue_core_test.sv]
// sorted_insert_priority_queue_core_test: self-checking bench for the sorted-insert max queue
// depends on spq_pkg, spq_in_if / spq_out_if and sorted_insert_priority_queue_core
// a shadow copy of the sorted array predicts every result word that no directed row pins, under random idling
`timescale 1ns / 100ps

module sorted_insert_priority_queue_core_test;

  localparam int              IDLE_LIMIT = 200;
  localparam int              RANDOM_WORDS = 475;
  localparam int              SEGMENT_LEN = 40;
  localparam spq_pkg::data_t  V_MAX = 32'sh7fffffff;
  localparam spq_pkg::data_t  V_MIN = 32'sh80000000;

  typedef struct packed {
    spq_pkg::data_t              popped;
    spq_pkg::data_t              top;
    logic [spq_pkg::COUNT_W-1:0] count;
    logic                        empty;
    spq_pkg::status_t            status;
  } report_t;

  typedef struct packed {
    spq_pkg::func_t func;
    spq_pkg::data_t value;
    logic           pinned;
    report_t        want;
  } stim_row_t;

  localparam report_t NO_REPORT = '{32'sd0, 32'sd0, 5'd0, 1'b0, spq_pkg::ST_OK};
  localparam int      NUM_ROWS = 25;

  // pinned rows carry the result that can be read straight off the spec
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{spq_pkg::FUNC_POP,  32'sd0,  1'b1, '{32'sd0, 32'sd0, 5'd0, 1'b1, spq_pkg::ST_EMPTY}},
    '{spq_pkg::FUNC_PUSH, V_MAX,   1'b1, '{32'sd0, V_MAX,  5'd1, 1'b0, spq_pkg::ST_OK}},
    '{spq_pkg::FUNC_PUSH, V_MIN,   1'b1, '{32'sd0, V_MAX,  5'd2, 1'b0, spq_pkg::ST_OK}},
    '{spq_pkg::FUNC_POP,  32'sd0,  1'b1, '{V_MAX,  V_MIN,  5'd1, 1'b0, spq_pkg::ST_OK}},
    '{spq_pkg::FUNC_POP,  -32'sd1, 1'b1, '{V_MIN,  32'sd0, 5'd0, 1'b1, spq_pkg::ST_OK}},
    '{spq_pkg::FUNC_POP,  V_MAX,   1'b1, '{32'sd0, 32'sd0, 5'd0, 1'b1, spq_pkg::ST_EMPTY}},
    '{spq_pkg::FUNC_PUSH, 32'sd0,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, -32'sd1,   1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd5,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd5,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, -32'sd100, 1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd5,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, V_MAX,     1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, V_MIN,     1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd1,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd2,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd3,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd4,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd6,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd7,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd8,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd9,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd10, 1'b1, '{32'sd0, V_MAX, 5'd16, 1'b0, spq_pkg::ST_FULL}},
    '{spq_pkg::FUNC_POP,  32'sd0,    1'b0, NO_REPORT},
    '{spq_pkg::FUNC_PUSH, 32'sd42,   1'b0, NO_REPORT}
  };

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_insert_priority_queue_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the sorted array, ascending, largest at shadow_count-1
  spq_pkg::data_t shadow_entries [spq_pkg::CAPACITY];
  int             shadow_count = 0;
  report_t        expected_reports [$];
  report_t        pinned_reports [$];
  logic           pinned_flags [$];
  int             fail_count = 0;
  int             idle_cycles = 0;
  bit             calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic report_t queue_op_report(spq_pkg::func_t f, spq_pkg::data_t v);
    report_t r;
    int      pos;
    r = NO_REPORT;
    if (f == spq_pkg::FUNC_PUSH) begin
      if (shadow_count >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // equal entries stay above the new word
        pos = shadow_count;
        while (pos > 0 && shadow_entries[pos-1] >= v) begin
          shadow_entries[pos] = shadow_entries[pos-1];
          pos--;
        end
        shadow_entries[pos] = v;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        shadow_count--;
        r.popped = shadow_entries[shadow_count];
      end
    end
    r.top   = (shadow_count == 0) ? 32'sd0 : shadow_entries[shadow_count-1];
    r.count = shadow_count[spq_pkg::COUNT_W-1:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  function automatic spq_pkg::data_t random_value();
    unique case ($urandom_range(0, 3))
      0: return spq_pkg::data_t'($urandom_range(0, 16)) - 32'sd8;
      1: begin
        unique case ($urandom_range(0, 3))
          0: return V_MAX;
          1: return V_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return spq_pkg::data_t'($urandom);
    endcase
  endfunction

  task automatic send_word(spq_pkg::func_t f, spq_pkg::data_t v, logic pinned,
                           report_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    pinned_flags   = {pinned_flags, pinned};
    pinned_reports = {pinned_reports, want};
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.value <= v;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // result side stalls independently of the input side
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    report_t want;
    report_t pred;
    logic    pinned;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.popped_value !== want.popped) begin
            $error("popped_value: expected %0d, got %0d", want.popped, out_ch.popped_value);
            fail_count++;
          end
          if (out_ch.top_value !== want.top) begin
            $error("top_value: expected %0d, got %0d", want.top, out_ch.top_value);
            fail_count++;
          end
          if (out_ch.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_ch.entry_count);
            fail_count++;
          end
          if (out_ch.is_empty !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, out_ch.is_empty);
            fail_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pred   = queue_op_report(in_ch.func, in_ch.value);
        pinned = pinned_flags.pop_front();
        want   = pinned_reports.pop_front();
        expected_reports = {expected_reports, (pinned ? want : pred)};
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sorted_insert_priority_queue_core_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int             n;
    int             push_pct;
    spq_pkg::func_t f;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = spq_pkg::FUNC_PUSH;
    in_ch.value  = '0;
    calm         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_word(directed_rows[i].func, directed_rows[i].value,
                directed_rows[i].pinned, directed_rows[i].want);
    end

    // alternate fill-heavy and drain-heavy stretches so the queue
    // keeps hitting full and empty
    push_pct = 75;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        push_pct = (push_pct > 50) ? 25 : 75;
        calm     = ($urandom_range(0, 3) == 0);
      end
      f = ($urandom_range(0, 99) < push_pct) ? spq_pkg::FUNC_PUSH : spq_pkg::FUNC_POP;
      send_word(f, random_value(), 1'b0, NO_REPORT);
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // let the monitor record the last accepted word first
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_insert_priority_queue_core_test OK");
    end else begin
      $display("sorted_insert_priority_queue_core_test NOT OK");
    end
    $finish;
  end

endmodule
